// ----- rtl/ssrt_pkg.sv -----
package ssrt_pkg;

  localparam int DEPTH       = 32;
  localparam int KEY_BITS    = 20;
  localparam int VALUE_BITS  = 32;
  localparam int MODE_BITS   = 3;
  localparam int STATUS_BITS = 2;
  localparam int COUNT_BITS  = 6;

  localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int ENTRY_W    = KEY_BITS + VALUE_BITS;
  localparam int IN_DATA_W  = ((KEY_BITS + VALUE_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((KEY_BITS + VALUE_BITS + COUNT_BITS + 7) / 8) * 8;
  localparam int OUT_USER_W = 1 + STATUS_BITS;

  localparam logic [MODE_BITS-1:0] MODE_INSERT = 3'd0;
  localparam logic [MODE_BITS-1:0] MODE_DELETE = 3'd1;
  localparam logic [MODE_BITS-1:0] MODE_GET    = 3'd2;
  localparam logic [MODE_BITS-1:0] MODE_ADD    = 3'd3;
  localparam logic [MODE_BITS-1:0] MODE_SET    = 3'd4;
  localparam logic [MODE_BITS-1:0] MODE_DUMP   = 3'd5;

  localparam logic [STATUS_BITS-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_FULL      = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_SRCH,
    S_SRCH_CMP,
    S_DEL_RD,
    S_DEL_WR,
    S_DUMP_RD,
    S_DUMP_OUT,
    S_RESP
  } state_t;

  typedef enum logic [1:0] {
    RD_MID,
    RD_PTR_DN,
    RD_PTR_UP,
    RD_PTR
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_SHIFT,
    WR_NEW,
    WR_UPD
  } wr_sel_t;

  typedef enum logic [1:0] {
    PTR_HOLD,
    PTR_INC,
    PTR_DEC,
    PTR_MID
  } ptr_op_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cnt_op_t;

  typedef enum logic [2:0] {
    OUT_INS,
    OUT_FULL,
    OUT_MISS,
    OUT_HIT,
    OUT_DUMP,
    OUT_EMPTY
  } out_sel_t;

  typedef struct packed {
    logic     load;
    logic     rd_en;
    rd_sel_t  rd_sel;
    logic     wr_en;
    wr_sel_t  wr_sel;
    ptr_op_t  ptr_op;
    logic     srch_lo;
    logic     srch_hi;
    logic     hit_load;
    cnt_op_t  cnt_op;
    logic     out_load;
    out_sel_t out_sel;
  } cmd_t;

  typedef struct packed {
    logic [MODE_BITS-1:0] mode;
    logic                 full;
    logic                 empty;
    logic                 ptr_zero;
    logic                 srch_open;
    logic                 key_eq;
    logic                 key_lt;
    logic                 del_more;
    logic                 dump_last;
    logic                 out_free;
  } stat_t;

  function automatic logic [COUNT_BITS-1:0] count_field(input logic [CNT_W-1:0] c);
    logic [63:0] w;
    w = 64'(c);
    return w[COUNT_BITS-1:0];
  endfunction

endpackage

// ----- rtl/ssrt_ram.sv -----
module ssrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/ssrt_ctrl.sv -----
module ssrt_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic [ssrt_pkg::MODE_BITS-1:0] in_mode,
  output logic                           in_ready,
  input  ssrt_pkg::stat_t                stat,
  output ssrt_pkg::cmd_t                 cmd
);

  ssrt_pkg::state_t   state_r, state_nxt;
  ssrt_pkg::out_sel_t resp_r, resp_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ssrt_pkg::S_IDLE;
      resp_r  <= ssrt_pkg::OUT_MISS;
    end else begin
      state_r <= state_nxt;
      resp_r  <= resp_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    resp_nxt     = resp_r;
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.rd_sel   = ssrt_pkg::RD_PTR;
    cmd.wr_sel   = ssrt_pkg::WR_SHIFT;
    cmd.ptr_op   = ssrt_pkg::PTR_HOLD;
    cmd.cnt_op   = ssrt_pkg::CNT_HOLD;
    cmd.out_sel  = resp_r;
    case (state_r)
      ssrt_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          case (in_mode)
            ssrt_pkg::MODE_INSERT: begin
              if (stat.full) begin
                resp_nxt  = ssrt_pkg::OUT_FULL;
                state_nxt = ssrt_pkg::S_RESP;
              end else begin
                state_nxt = ssrt_pkg::S_INS_RD;
              end
            end
            ssrt_pkg::MODE_DELETE, ssrt_pkg::MODE_GET,
            ssrt_pkg::MODE_ADD, ssrt_pkg::MODE_SET: begin
              state_nxt = ssrt_pkg::S_SRCH;
            end
            ssrt_pkg::MODE_DUMP: begin
              if (stat.empty) begin
                resp_nxt  = ssrt_pkg::OUT_EMPTY;
                state_nxt = ssrt_pkg::S_RESP;
              end else begin
                state_nxt = ssrt_pkg::S_DUMP_RD;
              end
            end
            default: state_nxt = ssrt_pkg::S_IDLE;
          endcase
        end
      end
      ssrt_pkg::S_INS_RD: begin
        if (stat.ptr_zero) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = ssrt_pkg::WR_NEW;
          cmd.cnt_op = ssrt_pkg::CNT_INC;
          resp_nxt   = ssrt_pkg::OUT_INS;
          state_nxt  = ssrt_pkg::S_RESP;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = ssrt_pkg::RD_PTR_DN;
          state_nxt  = ssrt_pkg::S_INS_CMP;
        end
      end
      ssrt_pkg::S_INS_CMP: begin
        cmd.wr_en = 1'b1;
        if (!stat.key_lt) begin
          cmd.wr_sel = ssrt_pkg::WR_SHIFT;
          cmd.ptr_op = ssrt_pkg::PTR_DEC;
          state_nxt  = ssrt_pkg::S_INS_RD;
        end else begin
          cmd.wr_sel = ssrt_pkg::WR_NEW;
          cmd.cnt_op = ssrt_pkg::CNT_INC;
          resp_nxt   = ssrt_pkg::OUT_INS;
          state_nxt  = ssrt_pkg::S_RESP;
        end
      end
      ssrt_pkg::S_SRCH: begin
        if (stat.srch_open) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = ssrt_pkg::RD_MID;
          cmd.ptr_op = ssrt_pkg::PTR_MID;
          state_nxt  = ssrt_pkg::S_SRCH_CMP;
        end else begin
          resp_nxt  = ssrt_pkg::OUT_MISS;
          state_nxt = ssrt_pkg::S_RESP;
        end
      end
      ssrt_pkg::S_SRCH_CMP: begin
        if (stat.key_eq) begin
          cmd.hit_load = 1'b1;
          cmd.wr_sel   = ssrt_pkg::WR_UPD;
          cmd.wr_en    = (stat.mode == ssrt_pkg::MODE_ADD) ||
                         (stat.mode == ssrt_pkg::MODE_SET);
          if (stat.mode == ssrt_pkg::MODE_DELETE) begin
            state_nxt = ssrt_pkg::S_DEL_RD;
          end else begin
            resp_nxt  = ssrt_pkg::OUT_HIT;
            state_nxt = ssrt_pkg::S_RESP;
          end
        end else if (stat.key_lt) begin
          cmd.srch_lo = 1'b1;
          state_nxt   = ssrt_pkg::S_SRCH;
        end else begin
          cmd.srch_hi = 1'b1;
          state_nxt   = ssrt_pkg::S_SRCH;
        end
      end
      ssrt_pkg::S_DEL_RD: begin
        if (stat.del_more) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = ssrt_pkg::RD_PTR_UP;
          state_nxt  = ssrt_pkg::S_DEL_WR;
        end else begin
          cmd.cnt_op = ssrt_pkg::CNT_DEC;
          resp_nxt   = ssrt_pkg::OUT_HIT;
          state_nxt  = ssrt_pkg::S_RESP;
        end
      end
      ssrt_pkg::S_DEL_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = ssrt_pkg::WR_SHIFT;
        cmd.ptr_op = ssrt_pkg::PTR_INC;
        state_nxt  = ssrt_pkg::S_DEL_RD;
      end
      ssrt_pkg::S_DUMP_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = ssrt_pkg::RD_PTR;
        state_nxt  = ssrt_pkg::S_DUMP_OUT;
      end
      ssrt_pkg::S_DUMP_OUT: begin
        cmd.out_sel = ssrt_pkg::OUT_DUMP;
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          if (stat.dump_last) begin
            state_nxt = ssrt_pkg::S_IDLE;
          end else begin
            cmd.ptr_op = ssrt_pkg::PTR_INC;
            state_nxt  = ssrt_pkg::S_DUMP_RD;
          end
        end
      end
      ssrt_pkg::S_RESP: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ssrt_pkg::S_IDLE;
        end
      end
      default: state_nxt = ssrt_pkg::S_IDLE;
    endcase
  end

endmodule

// ----- rtl/ssrt_dpath.sv -----
module ssrt_dpath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [ssrt_pkg::MODE_BITS-1:0]   in_mode,
  input  logic [ssrt_pkg::KEY_BITS-1:0]    in_key,
  input  logic [ssrt_pkg::VALUE_BITS-1:0]  in_value,
  input  ssrt_pkg::cmd_t                   cmd,
  output ssrt_pkg::stat_t                  stat,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic [ssrt_pkg::KEY_BITS-1:0]    out_key,
  output logic [ssrt_pkg::VALUE_BITS-1:0]  out_value,
  output logic                             out_found,
  output logic [ssrt_pkg::STATUS_BITS-1:0] out_status,
  output logic [ssrt_pkg::COUNT_BITS-1:0]  out_count,
  output logic                             out_last
);

  localparam int CW = ssrt_pkg::CNT_W;
  localparam int KB = ssrt_pkg::KEY_BITS;
  localparam int VB = ssrt_pkg::VALUE_BITS;

  logic [ssrt_pkg::MODE_BITS-1:0]   mode_r;
  logic [KB-1:0]                    key_r;
  logic [VB-1:0]                    value_r;
  logic [VB-1:0]                    hit_r;
  logic [CW-1:0]                    cnt_r, ptr_r, lo_r, hi_r;
  logic                             out_valid_r;
  logic [KB-1:0]                    out_key_r;
  logic [VB-1:0]                    out_value_r;
  logic                             out_found_r;
  logic [ssrt_pkg::STATUS_BITS-1:0] out_status_r;
  logic [ssrt_pkg::COUNT_BITS-1:0]  out_count_r;
  logic                             out_last_r;

  logic [CW:0]                      mid_sum;
  logic [CW-1:0]                    mid;
  logic [CW-1:0]                    rd_addr;
  logic [CW:0]                      ptr_p1;
  logic [ssrt_pkg::ENTRY_W-1:0]     rdata, wdata;
  logic [KB-1:0]                    rkey;
  logic [VB-1:0]                    rvalue, upd_value;
  logic                             out_free;

  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r} - (CW + 1)'(1);
  assign mid     = mid_sum[CW:1];
  assign ptr_p1  = {1'b0, ptr_r} + (CW + 1)'(1);
  assign rkey    = rdata[KB-1:0];
  assign rvalue  = rdata[ssrt_pkg::ENTRY_W-1:KB];

  always_comb begin
    case (cmd.rd_sel)
      ssrt_pkg::RD_MID:    rd_addr = mid;
      ssrt_pkg::RD_PTR_DN: rd_addr = ptr_r - CW'(1);
      ssrt_pkg::RD_PTR_UP: rd_addr = ptr_r + CW'(1);
      default:             rd_addr = ptr_r;
    endcase
  end

  always_comb begin
    case (mode_r)
      ssrt_pkg::MODE_ADD: upd_value = rvalue + value_r;
      ssrt_pkg::MODE_SET: upd_value = value_r;
      default:            upd_value = rvalue;
    endcase
  end

  always_comb begin
    case (cmd.wr_sel)
      ssrt_pkg::WR_NEW: wdata = {value_r, key_r};
      ssrt_pkg::WR_UPD: wdata = {upd_value, key_r};
      default:          wdata = rdata;
    endcase
  end

  ssrt_ram #(
    .WIDTH (ssrt_pkg::ENTRY_W),
    .DEPTH (ssrt_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (ptr_r[ssrt_pkg::IDX_W-1:0]),
    .wdata (wdata),
    .re    (cmd.rd_en),
    .raddr (rd_addr[ssrt_pkg::IDX_W-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      case (cmd.cnt_op)
        ssrt_pkg::CNT_INC: cnt_r <= cnt_r + CW'(1);
        ssrt_pkg::CNT_DEC: cnt_r <= cnt_r - CW'(1);
        default:           cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r  <= in_mode;
      key_r   <= in_key;
      value_r <= in_value;
      lo_r    <= '0;
      hi_r    <= cnt_r;
      ptr_r   <= (in_mode == ssrt_pkg::MODE_INSERT) ? cnt_r : '0;
    end else begin
      if (cmd.srch_lo) begin
        lo_r <= ptr_r + CW'(1);
      end
      if (cmd.srch_hi) begin
        hi_r <= ptr_r;
      end
      case (cmd.ptr_op)
        ssrt_pkg::PTR_INC: ptr_r <= ptr_r + CW'(1);
        ssrt_pkg::PTR_DEC: ptr_r <= ptr_r - CW'(1);
        ssrt_pkg::PTR_MID: ptr_r <= mid;
        default:           ptr_r <= ptr_r;
      endcase
    end
    if (cmd.hit_load) begin
      hit_r <= upd_value;
    end
  end

  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_count_r <= ssrt_pkg::count_field(cnt_r);
      out_last_r  <= (cmd.out_sel != ssrt_pkg::OUT_DUMP) || (ptr_p1 == {1'b0, cnt_r});
      case (cmd.out_sel)
        ssrt_pkg::OUT_INS: begin
          out_key_r    <= key_r;
          out_value_r  <= value_r;
          out_found_r  <= 1'b0;
          out_status_r <= ssrt_pkg::ST_OK;
        end
        ssrt_pkg::OUT_FULL: begin
          out_key_r    <= key_r;
          out_value_r  <= value_r;
          out_found_r  <= 1'b0;
          out_status_r <= ssrt_pkg::ST_FULL;
        end
        ssrt_pkg::OUT_HIT: begin
          out_key_r    <= key_r;
          out_value_r  <= hit_r;
          out_found_r  <= 1'b1;
          out_status_r <= ssrt_pkg::ST_OK;
        end
        ssrt_pkg::OUT_DUMP: begin
          out_key_r    <= rkey;
          out_value_r  <= rvalue;
          out_found_r  <= 1'b1;
          out_status_r <= ssrt_pkg::ST_OK;
        end
        ssrt_pkg::OUT_EMPTY: begin
          out_key_r    <= '0;
          out_value_r  <= '0;
          out_found_r  <= 1'b0;
          out_status_r <= ssrt_pkg::ST_OK;
        end
        default: begin
          out_key_r    <= key_r;
          out_value_r  <= '0;
          out_found_r  <= 1'b0;
          out_status_r <= ssrt_pkg::ST_NOT_FOUND;
        end
      endcase
    end
  end

  always_comb begin
    stat.mode      = mode_r;
    stat.full      = (cnt_r == CW'(ssrt_pkg::DEPTH));
    stat.empty     = (cnt_r == '0);
    stat.ptr_zero  = (ptr_r == '0);
    stat.srch_open = (lo_r < hi_r);
    stat.key_eq    = (rkey == key_r);
    stat.key_lt    = (rkey < key_r);
    stat.del_more  = (ptr_p1 < {1'b0, cnt_r});
    stat.dump_last = (ptr_p1 == {1'b0, cnt_r});
    stat.out_free  = out_free;
  end

  assign out_valid  = out_valid_r;
  assign out_key    = out_key_r;
  assign out_value  = out_value_r;
  assign out_found  = out_found_r;
  assign out_status = out_status_r;
  assign out_count  = out_count_r;
  assign out_last   = out_last_r;

endmodule

// ----- rtl/sorted_sparse_row_table.sv -----
// Sorted (key, value) table of up to 32 entries, kept in ascending key order.
// Input channel in_*: in_tuser carries the mode (insert, delete, get, add-to,
// set, dump), in_tdata the key and the Q16.16 value. Result channel out_*:
// key, value and entry count in out_tdata, found and status in out_tuser,
// out_tlast on the final result of an item. One item is worked at a time;
// in_tready is high only while the block is idle, and a finished result may
// still wait in the output register while the next item is taken.
// Table steps per item, set by the single entry RAM and its registered read port:
//   insert          a read and a write per entry at or above the insert point,
//                   one more read unless the entry goes first; none when full
//   get/add-to/set  a read per probe, with a write on an add-to or set hit
//   delete          a read per probe, then a read and a write per entry above
//                   the removed one
//   dump            a read and a result per entry; one result when empty
// At most 6 probes at 32 entries. Reset empties the table (entry count zero)
// and drops any pending result; the entry RAM itself is not cleared. While
// out_tready is low the result holds in out_tdata; the block takes at most one
// more item of a defined mode and stalls when that item's result is ready.
module sorted_sparse_row_table (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [ssrt_pkg::IN_DATA_W-1:0]  in_tdata,   // key, value
  input  logic [ssrt_pkg::MODE_BITS-1:0]  in_tuser,   // mode
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [ssrt_pkg::OUT_DATA_W-1:0] out_tdata,  // out_key, out_value, entry_count
  output logic [ssrt_pkg::OUT_USER_W-1:0] out_tuser,  // found, status
  output logic                            out_tlast
);

  localparam int KB = ssrt_pkg::KEY_BITS;
  localparam int VB = ssrt_pkg::VALUE_BITS;
  localparam int CB = ssrt_pkg::COUNT_BITS;

  ssrt_pkg::cmd_t                   cmd;
  ssrt_pkg::stat_t                  stat;
  logic                             in_ready;
  logic [KB-1:0]                    out_key;
  logic [VB-1:0]                    out_value;
  logic                             out_found;
  logic [ssrt_pkg::STATUS_BITS-1:0] out_status;
  logic [CB-1:0]                    out_count;

  ssrt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_mode  (in_tuser),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ssrt_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mode    (in_tuser),
    .in_key     (in_tdata[KB-1:0]),
    .in_value   (in_tdata[KB+VB-1:KB]),
    .cmd        (cmd),
    .stat       (stat),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .out_key    (out_key),
    .out_value  (out_value),
    .out_found  (out_found),
    .out_status (out_status),
    .out_count  (out_count),
    .out_last   (out_tlast)
  );

  assign in_tready = in_ready;

  always_comb begin
    out_tdata                      = '0;
    out_tdata[KB-1:0]              = out_key;
    out_tdata[KB+VB-1:KB]          = out_value;
    out_tdata[KB+VB+CB-1:KB+VB]    = out_count;
    out_tuser                      = {out_status, out_found};
  end

endmodule

// ----- rtl/ssrt_checker.sv -----
module ssrt_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [ssrt_pkg::MODE_BITS-1:0]  in_tuser,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [ssrt_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [ssrt_pkg::OUT_USER_W-1:0] out_tuser,
  input logic                            out_tlast
);

  localparam int KB = ssrt_pkg::KEY_BITS;
  localparam int VB = ssrt_pkg::VALUE_BITS;

  logic [ssrt_pkg::STATUS_BITS-1:0] status;
  logic [VB-1:0]                    value;

  assign status = out_tuser[ssrt_pkg::OUT_USER_W-1:1];
  assign value  = out_tdata[KB+VB-1:KB];

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
                                  $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser <= ssrt_pkg::MODE_DUMP) |=> !in_tready)
    else $error("new item taken while previous item is in work");

  a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (status != ssrt_pkg::ST_OK) |-> !out_tuser[0] && out_tlast)
    else $error("error result marked found or not last");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (status == ssrt_pkg::ST_NOT_FOUND) |-> (value == '0))
    else $error("absent key returned a nonzero value");

  a_full_echo: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (status == ssrt_pkg::ST_FULL) |->
      (out_tdata[KB+VB+ssrt_pkg::COUNT_BITS-1:KB+VB] ==
       ssrt_pkg::count_field(ssrt_pkg::CNT_W'(ssrt_pkg::DEPTH))))
    else $error("table full reported with a count below capacity");

endmodule

bind sorted_sparse_row_table ssrt_checker u_ssrt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

// ----- bench/sorted_sparse_row_table_test.sv -----
module sorted_sparse_row_table_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ssrt_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 200;

  typedef struct {
    logic [MODE_BITS-1:0]  mode;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
    bit                    drain;
  } row_op_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]    key;
    logic [VALUE_BITS-1:0]  value;
    logic                   found;
    logic [STATUS_BITS-1:0] status;
    logic [COUNT_BITS-1:0]  count;
    logic                   tail;
  } row_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [MODE_BITS-1:0]  in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic                  out_tlast;

  sorted_sparse_row_table uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  row_op_t               op_queue [$];
  row_result_t           awaited_rows [$];
  row_op_t               cur_op;
  logic [KEY_BITS-1:0]   row_keys [DEPTH];
  logic [VALUE_BITS-1:0] row_vals [DEPTH];
  int                    row_count = 0;
  int                    op_total = 1;
  int                    ops_taken = 0;
  int                    fail_count = 0;
  int                    cycle_count = 0;
  logic [KEY_BITS-1:0]   key_pool [$];

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int idle_phase();
    return (ops_taken * 3) / op_total;
  endfunction

  function automatic void queue_row(logic [KEY_BITS-1:0] key, logic [VALUE_BITS-1:0] value,
                                    logic found, logic [STATUS_BITS-1:0] status,
                                    logic tail);
    row_result_t r;
    r.key = key;
    r.value = value;
    r.found = found;
    r.status = status;
    r.count = COUNT_BITS'(row_count);
    r.tail = tail;
    awaited_rows.push_back(r);
  endfunction

  function automatic int find_row(logic [KEY_BITS-1:0] key);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = row_count - 1;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (row_keys[mid] == key) return mid;
      if (row_keys[mid] < key) lo = mid + 1;
      else hi = mid - 1;
    end
    return -1;
  endfunction

  function automatic void apply_row_op(row_op_t op);
    int pos;
    int i;
    logic [VALUE_BITS-1:0] old;
    case (op.mode)
      MODE_INSERT: begin
        if (row_count >= DEPTH) begin
          queue_row(op.key, op.value, 1'b0, ST_FULL, 1'b1);
        end else begin
          pos = 0;
          while (pos < row_count && row_keys[pos] < op.key) pos++;
          for (i = row_count - 1; i >= pos; i--) begin
            row_keys[i + 1] = row_keys[i];
            row_vals[i + 1] = row_vals[i];
          end
          row_keys[pos] = op.key;
          row_vals[pos] = op.value;
          row_count++;
          queue_row(op.key, op.value, 1'b0, ST_OK, 1'b1);
        end
      end
      MODE_DUMP: begin
        if (row_count == 0) begin
          queue_row('0, '0, 1'b0, ST_OK, 1'b1);
        end else begin
          for (i = 0; i < row_count; i++)
            queue_row(row_keys[i], row_vals[i], 1'b1, ST_OK, i == row_count - 1);
        end
      end
      MODE_DELETE, MODE_GET, MODE_ADD, MODE_SET: begin
        pos = find_row(op.key);
        if (pos < 0) begin
          queue_row(op.key, '0, 1'b0, ST_NOT_FOUND, 1'b1);
        end else if (op.mode == MODE_DELETE) begin
          old = row_vals[pos];
          for (i = pos; i < row_count - 1; i++) begin
            row_keys[i] = row_keys[i + 1];
            row_vals[i] = row_vals[i + 1];
          end
          row_count--;
          queue_row(op.key, old, 1'b1, ST_OK, 1'b1);
        end else begin
          if (op.mode == MODE_ADD) row_vals[pos] = row_vals[pos] + op.value;
          else if (op.mode == MODE_SET) row_vals[pos] = op.value;
          queue_row(op.key, row_vals[pos], 1'b1, ST_OK, 1'b1);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void add_op(logic [MODE_BITS-1:0] mode, logic [KEY_BITS-1:0] key,
                                 logic [VALUE_BITS-1:0] value, bit drain);
    row_op_t op;
    op.mode = mode;
    op.key = key;
    op.value = value;
    op.drain = drain;
    op_queue.push_back(op);
    if (mode == MODE_INSERT) key_pool.push_back(key);
  endfunction

  function automatic logic [KEY_BITS-1:0] pick_key();
    if (key_pool.size() != 0 && $urandom_range(99) < 70)
      return key_pool[$urandom_range(key_pool.size() - 1)];
    if ($urandom_range(1) == 0) return KEY_BITS'($urandom_range(63));
    return KEY_BITS'($urandom);
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        apply_row_op(cur_op);
        ops_taken++;
      end
      if (!in_tvalid || in_tready) begin
        if (op_queue.size() != 0 && !(op_queue[0].drain && awaited_rows.size() != 0) &&
            !(idle_phase() == 0 && $urandom_range(99) < 37) &&
            !(idle_phase() == 1 && $urandom_range(99) < 53)) begin
          cur_op = op_queue.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= cur_op.mode;
          in_tdata <= IN_DATA_W'({cur_op.value, cur_op.key});
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    row_result_t got;
    row_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.key = out_tdata[KEY_BITS-1:0];
        got.value = out_tdata[KEY_BITS +: VALUE_BITS];
        got.count = out_tdata[KEY_BITS + VALUE_BITS +: COUNT_BITS];
        got.found = out_tuser[0];
        got.status = out_tuser[1 +: STATUS_BITS];
        got.tail = out_tlast;
        if (awaited_rows.size() == 0) begin
          $display("%0t: unexpected result key=%h value=%h found=%b status=%0d count=%0d last=%b",
                   $time, got.key, got.value, got.found, got.status, got.count, got.tail);
          fail_count++;
        end else begin
          want = awaited_rows.pop_front();
          if (got.key !== want.key || got.value !== want.value || got.found !== want.found ||
              got.status !== want.status || got.count !== want.count ||
              got.tail !== want.tail) begin
            $display("%0t: expected key=%h value=%h found=%b status=%0d count=%0d last=%b",
                     $time, want.key, want.value, want.found, want.status, want.count,
                     want.tail);
            $display("%0t:   actual key=%h value=%h found=%b status=%0d count=%0d last=%b",
                     $time, got.key, got.value, got.found, got.status, got.count, got.tail);
            fail_count++;
          end
        end
      end
      case (idle_phase())
        0: out_tready <= $urandom_range(99) >= 53;
        1: out_tready <= $urandom_range(99) >= 37;
        default: out_tready <= 1'b1;
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int counted;
    int pick;
    for (int i = 0; i < DEPTH; i++) begin
      row_keys[i] = '0;
      row_vals[i] = '0;
    end

    add_op(MODE_DUMP, '0, '0, 1'b0);
    add_op(MODE_GET, 20'd5, '0, 1'b0);
    add_op(MODE_DELETE, 20'd5, '0, 1'b0);
    add_op(MODE_INSERT, 20'h00000, 32'h8000_0000, 1'b0);
    add_op(MODE_INSERT, 20'hFFFFF, 32'h7FFF_FFFF, 1'b0);
    add_op(MODE_INSERT, 20'd100, 32'h0001_0000, 1'b0);
    add_op(MODE_INSERT, 20'd100, 32'hFFFF_0000, 1'b0);
    add_op(MODE_INSERT, 20'd50, 32'hFFFF_FFFF, 1'b0);
    add_op(MODE_GET, 20'd100, '0, 1'b0);
    add_op(MODE_GET, 20'h00000, '0, 1'b0);
    add_op(MODE_GET, 20'hFFFFF, '0, 1'b0);
    add_op(MODE_ADD, 20'hFFFFF, 32'h0000_0001, 1'b0);
    add_op(MODE_ADD, 20'h00000, 32'hFFFF_FFFF, 1'b0);
    add_op(MODE_SET, 20'd50, 32'h1234_5678, 1'b0);
    add_op(MODE_SET, 20'd77, 32'hDEAD_BEEF, 1'b0);
    add_op(MODE_ADD, 20'd77, 32'h0000_0100, 1'b0);
    add_op(MODE_DELETE, 20'd100, '0, 1'b0);
    add_op(MODE_DELETE, 20'd100, '0, 1'b0);
    add_op(MODE_DELETE, 20'd100, '0, 1'b0);
    add_op(3'd6, 20'hABCDE, 32'h5555_AAAA, 1'b0);
    add_op(3'd7, 20'h54321, 32'hAAAA_5555, 1'b0);
    add_op(MODE_DUMP, '0, '0, 1'b0);
    add_op(MODE_DELETE, 20'h00000, '0, 1'b0);
    add_op(MODE_GET, 20'h00000, '0, 1'b0);
    add_op(MODE_DUMP, '0, '0, 1'b1);

    // fill past capacity so full-table inserts get rejected
    for (int i = 0; i < 34; i++)
      add_op(MODE_INSERT, pick_key(), $urandom, i == 0);
    add_op(MODE_DUMP, '0, '0, 1'b0);

    counted = 0;
    while (counted < 40) begin
      pick = $urandom_range(99);
      if (pick < 25) add_op(MODE_INSERT, pick_key(), $urandom, 1'b0);
      else if (pick < 45) add_op(MODE_DELETE, pick_key(), $urandom, 1'b0);
      else if (pick < 60) add_op(MODE_GET, pick_key(), $urandom, 1'b0);
      else if (pick < 72) add_op(MODE_ADD, pick_key(), $urandom, 1'b0);
      else if (pick < 84) add_op(MODE_SET, pick_key(), $urandom, 1'b0);
      else if (pick < 92) add_op(MODE_DUMP, KEY_BITS'($urandom), $urandom, 1'b0);
      else if (pick < 96) add_op(MODE_GET, pick_key(), $urandom, 1'b1);
      else begin
        add_op(MODE_BITS'($urandom_range(7, 6)), KEY_BITS'($urandom), $urandom, 1'b0);
        counted--;
      end
      counted++;
    end
    op_total = op_queue.size();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (op_queue.size() != 0 || in_tvalid) @(posedge clk);
    while (awaited_rows.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/ssrt_pkg.sv
rtl/ssrt_ram.sv
rtl/ssrt_ctrl.sv
rtl/ssrt_dpath.sv
rtl/sorted_sparse_row_table.sv
rtl/ssrt_checker.sv
bench/sorted_sparse_row_table_test.sv
